/* src/tlc_pkg.sv */
`default_nettype none

package tlc_pkg;

  // Cache geometry
  localparam int FIRST_SETS         = 2;
  localparam int FIRST_WAYS         = 4;
  localparam int FIRST_OFFSET_BITS  = 5;
  localparam int SECOND_SETS        = 4;
  localparam int SECOND_WAYS        = 4;
  localparam int SECOND_OFFSET_BITS = 6;

  // Field widths
  localparam int ADDR_W     = 32;
  localparam int LAT_W      = 8;
  localparam int COST_W     = 10;
  localparam int TIME_W     = 48;
  localparam int COUNT_W    = 32;
  localparam int LEVEL_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Set index uses floor(log2(SETS)) bits; upper sets of a count that is not a power of two are never used
  localparam int F_IB    = $clog2(FIRST_SETS + 1) - 1;
  localparam int S_IB    = $clog2(SECOND_SETS + 1) - 1;
  localparam int F_ROWS  = 1 << F_IB;
  localparam int S_ROWS  = 1 << S_IB;
  localparam int F_IDX_W = (F_IB > 0) ? F_IB : 1;
  localparam int S_IDX_W = (S_IB > 0) ? S_IB : 1;
  localparam logic [ADDR_W-1:0] F_IDX_MASK = ADDR_W'((64'd1 << F_IB) - 64'd1);
  localparam logic [ADDR_W-1:0] S_IDX_MASK = ADDR_W'((64'd1 << S_IB) - 64'd1);

  localparam int F_TAG_W = ADDR_W - FIRST_OFFSET_BITS - F_IB;
  localparam int S_TAG_W = ADDR_W - SECOND_OFFSET_BITS - S_IB;
  localparam int TAG_W   = (F_TAG_W > S_TAG_W) ? F_TAG_W : S_TAG_W;

  localparam int MAX_WAYS = (FIRST_WAYS > SECOND_WAYS) ? FIRST_WAYS : SECOND_WAYS;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W    = $clog2(MAX_WAYS + 1);

  localparam logic [MAX_WAYS-1:0] F_PRESENT = MAX_WAYS'((64'd1 << FIRST_WAYS) - 64'd1);
  localparam logic [MAX_WAYS-1:0] S_PRESENT = MAX_WAYS'((64'd1 << SECOND_WAYS) - 64'd1);

  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [WAY_W-1:0] rank_t;

  typedef enum logic [LEVEL_W-1:0] {
    LVL_FIRST  = 2'd0,
    LVL_SECOND = 2'd1,
    LVL_MEMORY = 2'd2
  } level_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_L1_LATENCY  = 3'd0,
    REG_L2_LATENCY  = 3'd1,
    REG_MEM_LATENCY = 3'd2,
    REG_L1_POLICY   = 3'd3,
    REG_L2_POLICY   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_FIRST  = 2'd1,
    ST_SECOND = 2'd2
  } state_t;

  // One set of one level, presented to the shared way unit
  typedef struct packed {
    logic [MAX_WAYS-1:0] present;
    logic [MAX_WAYS-1:0] valid;
    tag_t [MAX_WAYS-1:0] tags;
    rank_t [MAX_WAYS-1:0] ranks;
    tag_t                tag;
    logic                lru;
  } way_req_t;

  typedef struct packed {
    logic                hit;
    logic [MAX_WAYS-1:0] valid;
    logic [MAX_WAYS-1:0] tag_we;
    rank_t [MAX_WAYS-1:0] ranks;
  } way_resp_t;

  typedef struct packed {
    logic              en;
    level_t            level;
    logic [COST_W-1:0] cost;
  } commit_t;

endpackage

`default_nettype wire

/* src/tlc_way_unit.sv */
`default_nettype none

module tlc_way_unit import tlc_pkg::*; (
  input  way_req_t  req,
  output way_resp_t resp
);

  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] free;
  logic [MAX_WAYS-1:0] valid_new;
  logic                hit;
  logic                has_free;
  logic                was_valid;
  logic                do_update;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    victim;
  logic [WAY_W-1:0]    target;
  logic [CNT_W-1:0]    count;
  rank_t               newest;

  always_comb begin
    match = '0;
    free  = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      match[i] = req.present[i] & req.valid[i] & (req.tags[i] == req.tag);
      free[i]  = req.present[i] & ~req.valid[i];
    end
    hit      = |match;
    has_free = |free;

    // lowest-numbered matching and free ways
    hit_way  = '0;
    free_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (match[i]) hit_way = WAY_W'(i);
      if (free[i]) free_way = WAY_W'(i);
    end

    // oldest way, first one wins on a tie
    victim = '0;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (req.present[i] && (req.ranks[i] < req.ranks[victim])) victim = WAY_W'(i);
    end

    target    = hit ? hit_way : (has_free ? free_way : victim);
    was_valid = hit | ~has_free;
    do_update = ~hit | req.lru;

    valid_new = req.valid;
    if (!hit && has_free) valid_new[target] = 1'b1;

    count  = CNT_W'($countones(valid_new & req.present));
    newest = rank_t'(count - CNT_W'(1));

    resp.hit    = hit;
    resp.valid  = valid_new;
    resp.tag_we = '0;
    resp.ranks  = req.ranks;
    if (!hit) resp.tag_we[target] = 1'b1;
    // promote target to newest, close the gap it leaves
    if (do_update) begin
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (WAY_W'(i) == target) begin
          resp.ranks[i] = newest;
        end else if (was_valid && valid_new[i] && (req.ranks[i] > req.ranks[target])) begin
          resp.ranks[i] = req.ranks[i] - rank_t'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

/* src/tlc_stats.sv */
`default_nettype none

module tlc_stats import tlc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  commit_t            commit,
  output logic [TIME_W-1:0]  total_time,
  output logic [COUNT_W-1:0] first_hits,
  output logic [COUNT_W-1:0] first_misses,
  output logic [COUNT_W-1:0] second_hits,
  output logic [COUNT_W-1:0] second_misses
);

  localparam int TIME_WX = TIME_W + 1;

  logic [TIME_WX-1:0] time_sum_wide;
  logic [TIME_W-1:0]  time_next;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (&c) ? c : c + COUNT_W'(1);
  endfunction

  assign time_sum_wide = {1'b0, total_time} + TIME_WX'(commit.cost);
  // clamp on carry out
  assign time_next = time_sum_wide[TIME_W] ? {TIME_W{1'b1}} : time_sum_wide[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      total_time    <= '0;
      first_hits    <= '0;
      first_misses  <= '0;
      second_hits   <= '0;
      second_misses <= '0;
    end else if (commit.en) begin
      total_time <= time_next;
      case (commit.level)
        LVL_FIRST: begin
          first_hits <= sat_inc(first_hits);
        end
        LVL_SECOND: begin
          first_misses <= sat_inc(first_misses);
          second_hits  <= sat_inc(second_hits);
        end
        LVL_MEMORY: begin
          first_misses  <= sat_inc(first_misses);
          second_misses <= sat_inc(second_misses);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/two_level_cache_tag_model_top.sv */
// Two-level set-associative cache tag model. Each accepted address is looked up in the
// first-level tag array and, on a miss, in the second-level array; a level that misses
// allocates the block into its first invalid way or else its oldest way, and reports the
// level that held the data, the cycles charged, the running time and saturating hit and
// miss counts. One shared way unit (tag compare, victim pick, rank update) serves both
// levels, one level per cycle unless the last lookup waits on a stalled output: an
// access hitting the first level passes accept and the first-level lookup, a miss there
// also the second-level lookup. The tag arrays are flip-flops with per-way valid bits
// cleared by reset, so no clearing pass is needed. Configuration writes are always taken
// (cfg_ready is tied high) and belong in idle periods only.
`default_nettype none

module two_level_cache_tag_model_top import tlc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADDR_W-1:0]     address,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LEVEL_W-1:0]    found_level,
  output logic [COST_W-1:0]     access_cost,
  output logic [TIME_W-1:0]     total_time,
  output logic [COUNT_W-1:0]    first_hits,
  output logic [COUNT_W-1:0]    first_misses,
  output logic [COUNT_W-1:0]    second_hits,
  output logic [COUNT_W-1:0]    second_misses,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state;
  state_t state_next;

  logic [ADDR_W-1:0] address_q;
  logic [LAT_W-1:0]  l1_latency;
  logic [LAT_W-1:0]  l2_latency;
  logic [LAT_W-1:0]  memory_latency;
  logic              l1_policy;
  logic              l2_policy;

  logic [MAX_WAYS-1:0] first_valid [F_ROWS];
  logic [F_TAG_W-1:0]  first_tags [F_ROWS][MAX_WAYS];
  rank_t               first_rank [F_ROWS][MAX_WAYS];
  logic [MAX_WAYS-1:0] second_valid [S_ROWS];
  logic [S_TAG_W-1:0]  second_tags [S_ROWS][MAX_WAYS];
  rank_t               second_rank [S_ROWS][MAX_WAYS];

  logic [F_IDX_W-1:0] f_set;
  logic [F_TAG_W-1:0] f_tag;
  logic [S_IDX_W-1:0] s_set;
  logic [S_TAG_W-1:0] s_tag;

  way_req_t  req;
  way_resp_t resp;
  commit_t   commit;
  logic      first_we;
  logic      second_we;
  logic      out_free;
  level_t    found_q;

  assign f_set = F_IDX_W'((address_q >> FIRST_OFFSET_BITS) & F_IDX_MASK);
  assign f_tag = F_TAG_W'(address_q >> (FIRST_OFFSET_BITS + F_IB));
  assign s_set = S_IDX_W'((address_q >> SECOND_OFFSET_BITS) & S_IDX_MASK);
  assign s_tag = S_TAG_W'(address_q >> (SECOND_OFFSET_BITS + S_IB));

  assign in_stall    = (state != ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_free    = !out_valid || !out_stall;
  assign found_level = found_q;

  // Present the set of the level under work to the shared unit
  always_comb begin
    if (state == ST_SECOND) begin
      req.present = S_PRESENT;
      req.valid   = second_valid[s_set];
      req.tag     = TAG_W'(s_tag);
      req.lru     = l2_policy;
      for (int i = 0; i < MAX_WAYS; i++) begin
        req.tags[i]  = TAG_W'(second_tags[s_set][i]);
        req.ranks[i] = second_rank[s_set][i];
      end
    end else begin
      req.present = F_PRESENT;
      req.valid   = first_valid[f_set];
      req.tag     = TAG_W'(f_tag);
      req.lru     = l1_policy;
      for (int i = 0; i < MAX_WAYS; i++) begin
        req.tags[i]  = TAG_W'(first_tags[f_set][i]);
        req.ranks[i] = first_rank[f_set][i];
      end
    end
  end

  tlc_way_unit u_way (
    .req  (req),
    .resp (resp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    first_we     = 1'b0;
    second_we    = 1'b0;
    commit.en    = 1'b0;
    commit.level = LVL_FIRST;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_FIRST;
      end
      ST_FIRST: begin
        if (resp.hit) begin
          // hold until the result register can take the transaction
          if (out_free) begin
            first_we     = 1'b1;
            commit.en    = 1'b1;
            commit.level = LVL_FIRST;
            state_next   = ST_IDLE;
          end
        end else begin
          first_we   = 1'b1;
          state_next = ST_SECOND;
        end
      end
      ST_SECOND: begin
        if (out_free) begin
          second_we    = 1'b1;
          commit.en    = 1'b1;
          commit.level = resp.hit ? LVL_SECOND : LVL_MEMORY;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    commit.cost = COST_W'(l1_latency)
                + ((commit.level != LVL_FIRST) ? COST_W'(l2_latency) : COST_W'(0))
                + ((commit.level == LVL_MEMORY) ? COST_W'(memory_latency) : COST_W'(0));
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) address_q <= address;
  end

  // Valid bits and ranks
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < F_ROWS; r++) begin
        first_valid[r] <= '0;
        for (int w = 0; w < MAX_WAYS; w++) first_rank[r][w] <= '0;
      end
      for (int r = 0; r < S_ROWS; r++) begin
        second_valid[r] <= '0;
        for (int w = 0; w < MAX_WAYS; w++) second_rank[r][w] <= '0;
      end
    end else begin
      if (first_we) begin
        first_valid[f_set] <= resp.valid;
        for (int w = 0; w < MAX_WAYS; w++) first_rank[f_set][w] <= resp.ranks[w];
      end
      if (second_we) begin
        second_valid[s_set] <= resp.valid;
        for (int w = 0; w < MAX_WAYS; w++) second_rank[s_set][w] <= resp.ranks[w];
      end
    end
  end

  // Tags
  always_ff @(posedge clk) begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (first_we && resp.tag_we[w]) first_tags[f_set][w] <= f_tag;
      if (second_we && resp.tag_we[w]) second_tags[s_set][w] <= s_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_latency     <= LAT_W'(1);
      l2_latency     <= LAT_W'(8);
      memory_latency <= LAT_W'(80);
      l1_policy      <= 1'b1;
      l2_policy      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_L1_LATENCY:  l1_latency     <= cfg_data;
        REG_L2_LATENCY:  l2_latency     <= cfg_data;
        REG_MEM_LATENCY: memory_latency <= cfg_data;
        REG_L1_POLICY:   l1_policy      <= cfg_data[0];
        REG_L2_POLICY:   l2_policy      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit.en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit.en) begin
      found_q     <= commit.level;
      access_cost <= commit.cost;
    end
  end

  tlc_stats u_stats (
    .clk           (clk),
    .rst           (rst),
    .commit        (commit),
    .total_time    (total_time),
    .first_hits    (first_hits),
    .first_misses  (first_misses),
    .second_hits   (second_hits),
    .second_misses (second_misses)
  );

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    commit.en |=> out_valid)
    else $error("committed access did not reach the result register");

  a_level_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (found_q == LVL_FIRST || found_q == LVL_SECOND || found_q == LVL_MEMORY))
    else $error("illegal found level");

  a_first_cost: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found_q == LVL_FIRST) |-> (access_cost == COST_W'(l1_latency)))
    else $error("first-level hit charged wrong cost");

  a_second_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SECOND) |-> ($past(state) == ST_FIRST || $past(state) == ST_SECOND))
    else $error("second-level lookup entered without first-level miss");

endmodule

`default_nettype wire
